>>> rtl/core/smv_pkg.sv
`timescale 1ns / 1ps

package smv_pkg;

  // Default configuration of the block.
  localparam int unsigned DefVecDepth = 1024;
  localparam int unsigned DefFracBits = 16;

  // Number of entries in the queue between the front and the back end.
  localparam int unsigned QueueDepth  = 4;

  // Field widths fixed by the transaction format.
  localparam int unsigned OpcodeW = 2;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RowW    = 16;
  localparam int unsigned AccW    = 64;

  // Opcodes of an input transaction.
  typedef logic [OpcodeW-1:0] opcode_t;
  localparam opcode_t OP_LOAD    = 2'd0;
  localparam opcode_t OP_NONZERO = 2'd1;
  localparam opcode_t OP_EMPTY   = 2'd2;

  // Input transaction.
  typedef struct packed {
    opcode_t                  opcode;
    logic [IndexW-1:0]        index;
    logic signed [DataW-1:0]  value;
    logic                     row_end;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic [RowW-1:0]          row_number;
    logic signed [DataW-1:0]  row_value;
    logic                     saturated;
  } out_item_t;

  // Work item handed from the front end to the back end.
  typedef struct packed {
    opcode_t                  opcode;
    logic signed [DataW-1:0]  value;
    logic signed [DataW-1:0]  vec_value;
    logic                     row_end;
  } work_t;

endpackage

>>> rtl/core/sparse_matrix_vector_multiply.sv
`timescale 1ns / 1ps

// Sparse matrix-vector multiply over a row-compressed stream in signed
// fixed point with FracBits fraction bits. Load the dense vector with load
// transactions (which also restart row numbering), then stream each row's
// nonzeros as (column, value) pairs, marking the last with row_end; empty
// rows use their own opcode and yield zero. Each finished row produces one
// output transaction with its number, its sum clipped to 32 bits and a flag
// that reports the clipping. The block takes one transaction per cycle when
// the output is not stalled; after its last nonzero is accepted, a row result
// passes through the registered vector store read, the four-entry queue,
// the 32 x 32 multiply register and the 64-bit accumulate that fills the
// output register. The single read port of the vector store sets the rate at
// one nonzero per cycle when the output is not stalled.
// Reading a vector element that was never loaded returns an undefined value.
module sparse_matrix_vector_multiply
  import smv_pkg::*;
#(
  parameter int unsigned VecDepth = DefVecDepth,
  parameter int unsigned FracBits = DefFracBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic  push_valid;
  logic  push_ready;
  work_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_item;

  // Front end: accepts transactions, writes and reads the vector store.
  smv_front #(
    .VecDepth (VecDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Queue that decouples the two ends.
  smv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back end: multiply, accumulate and emit row results.
  smv_back #(
    .FracBits (FracBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/core/smv_ram.sv
`timescale 1ns / 1ps

module smv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/smv_front.sv
`timescale 1ns / 1ps

module smv_front
  import smv_pkg::*;
#(
  parameter int unsigned VecDepth = DefVecDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output work_t    push_item_o
);

  localparam int unsigned AddrW  = (VecDepth > 1) ? $clog2(VecDepth) : 1;
  localparam bit          IsPow2 = ((VecDepth & (VecDepth - 1)) == 0);
  localparam bit          Direct = IsPow2 || (VecDepth >= (1 << IndexW));
  // Reciprocal of the depth, scaled by 2^20, for the index reduction.
  localparam int unsigned RecipShift = 20;
  localparam int unsigned Recip      = (1 << RecipShift) / VecDepth;

  logic             accept;
  logic             known_op;
  logic [AddrW-1:0] pos;
  logic [31:0]      q_prod;
  logic [31:0]      q_est;
  logic [31:0]      rem;
  logic [DataW-1:0] rdata;

  logic             s1_valid_q, s1_valid_d;
  opcode_t          s1_opcode_q;
  logic [DataW-1:0] s1_value_q;
  logic             s1_row_end_q;

  // The stage register may take a new transaction when it is empty or draining.
  assign in_ready_o = !s1_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign known_op   = (in_item_i.opcode == OP_LOAD) || (in_item_i.opcode == OP_NONZERO) ||
                      (in_item_i.opcode == OP_EMPTY);

  // Reduce the index modulo the vector depth. Powers of two and depths that
  // cover the whole index range need no arithmetic; otherwise a reciprocal
  // estimate of the quotient is corrected by one compare and subtract.
  always_comb begin
    q_prod = 32'(in_item_i.index) * 32'(Recip);
    q_est  = q_prod >> RecipShift;
    rem    = 32'(in_item_i.index) - q_est * 32'(VecDepth);
    if (rem >= 32'(VecDepth)) begin
      rem = rem - 32'(VecDepth);
    end
    if (Direct) begin
      pos = AddrW'(in_item_i.index);
    end else begin
      pos = AddrW'(rem);
    end
  end

  // Vector store: loads write it, nonzeros read it in the same cycle.
  smv_ram #(
    .Width (DataW),
    .Depth (VecDepth)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (in_item_i.opcode == OP_LOAD)),
    .waddr_i (pos),
    .wdata_i (in_item_i.value),
    .re_i    (accept && (in_item_i.opcode == OP_NONZERO)),
    .raddr_i (pos),
    .rdata_o (rdata)
  );

  // Stage register that waits for the read data. Opcode three is dropped here.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = accept && known_op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_opcode_q  <= in_item_i.opcode;
      s1_value_q   <= in_item_i.value;
      s1_row_end_q <= in_item_i.row_end;
    end
  end

  // The read data stays valid while stalled, as no new access is started.
  assign push_valid_o          = s1_valid_q;
  assign push_item_o.opcode    = s1_opcode_q;
  assign push_item_o.value     = s1_value_q;
  assign push_item_o.vec_value = rdata;
  assign push_item_o.row_end   = s1_row_end_q;

endmodule

>>> rtl/core/smv_queue.sv
`timescale 1ns / 1ps

module smv_queue
  import smv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  work_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output work_t pop_item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  work_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/core/smv_back.sv
`timescale 1ns / 1ps

module smv_back
  import smv_pkg::*;
#(
  parameter int unsigned FracBits = DefFracBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  work_t     pop_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam logic signed [AccW-1:0] Max32 = AccW'(64'sd2147483647);
  localparam logic signed [AccW-1:0] Min32 = -AccW'(64'sd2147483648);

  logic                   advance;
  logic                   pop;
  logic                   step;

  logic                   m_valid_q;
  opcode_t                m_opcode_q;
  logic                   m_row_end_q;
  logic signed [AccW-1:0] m_prod_q;
  logic signed [AccW-1:0] m_prod_d;

  logic signed [AccW-1:0] acc_q, acc_d;
  logic [RowW-1:0]        row_q, row_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic signed [AccW-1:0] shifted;
  logic signed [AccW:0]   wide_sum;
  logic signed [AccW-1:0] sum;
  logic signed [AccW-1:0] clip_in;
  logic                   emit;

  assign advance     = !out_valid_q || out_ready_i;
  assign pop_ready_o = !m_valid_q || advance;
  assign pop         = pop_valid_i && pop_ready_o;
  assign step        = m_valid_q && advance;

  // Multiply stage: exact 32 x 32 signed product.
  assign m_prod_d = AccW'(pop_item_i.value) * AccW'(pop_item_i.vec_value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      m_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_opcode_q  <= pop_item_i.opcode;
      m_row_end_q <= pop_item_i.row_end;
      m_prod_q    <= m_prod_d;
    end
  end

  // Accumulate stage: floor shift, saturating add, clip on emission.
  always_comb begin
    shifted  = m_prod_q >>> FracBits;
    wide_sum = {acc_q[AccW-1], acc_q} + {shifted[AccW-1], shifted};
    if (wide_sum[AccW] != wide_sum[AccW-1]) begin
      sum = wide_sum[AccW] ? {1'b1, {(AccW - 1){1'b0}}} : {1'b0, {(AccW - 1){1'b1}}};
    end else begin
      sum = wide_sum[AccW-1:0];
    end

    acc_d       = acc_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    emit        = 1'b0;
    clip_in     = '0;

    if (advance) begin
      out_valid_d = 1'b0;
    end

    if (step) begin
      case (m_opcode_q)
        OP_LOAD: begin
          acc_d = '0;
          row_d = '0;
        end
        OP_NONZERO: begin
          if (m_row_end_q) begin
            emit    = 1'b1;
            clip_in = sum;
          end else begin
            acc_d = sum;
          end
        end
        OP_EMPTY: begin
          emit = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      out_valid_d           = 1'b1;
      out_item_d.row_number = row_q;
      if (clip_in > Max32) begin
        out_item_d.row_value = DataW'(Max32);
        out_item_d.saturated = 1'b1;
      end else if (clip_in < Min32) begin
        out_item_d.row_value = DataW'(Min32);
        out_item_d.saturated = 1'b1;
      end else begin
        out_item_d.row_value = DataW'(clip_in);
        out_item_d.saturated = 1'b0;
      end
      acc_d = '0;
      row_d = row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> test/smv_row_check.sv
`timescale 1ns / 1ps

// Watches both channels of the sparse matrix-vector multiply, keeps its own
// copy of the vector store, row sum and row number, and compares every row
// result with the oldest one that it expects.
module smv_row_check
  import smv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned FracBits = DefFracBits;

  logic signed [DataW-1:0] vec_mem [DefVecDepth];
  logic signed [AccW-1:0]  row_sum;
  logic [RowW-1:0]         row_idx;
  out_item_t               expected_rows [$];
  int unsigned             fail_count;

  // Clips the row sum to 32 bits, queues the row result and starts a new row.
  task automatic close_row(input logic signed [AccW-1:0] sum);
    out_item_t row;
    row.row_number = row_idx;
    row.saturated  = 1'b0;
    if (sum > 64'sd2147483647) begin
      row.row_value = 32'h7FFF_FFFF;
      row.saturated = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      row.row_value = 32'h8000_0000;
      row.saturated = 1'b1;
    end else begin
      row.row_value = sum[DataW-1:0];
    end
    expected_rows.push_back(row);
    row_idx = row_idx + 1'b1;
    row_sum = '0;
  endtask

  // Applies one accepted input transaction to the predicted state.
  task automatic predict_row(input in_item_t item);
    logic signed [AccW-1:0] lhs;
    logic signed [AccW-1:0] rhs;
    logic signed [AccW-1:0] product;
    logic [AccW:0]          wide;
    case (item.opcode)
      OP_LOAD: begin
        vec_mem[item.index] = item.value;
        row_sum = '0;
        row_idx = '0;
      end
      OP_NONZERO: begin
        lhs = $signed(item.value);
        rhs = vec_mem[item.index];
        // The product is exact in 64 bits; the arithmetic shift floors it.
        product = lhs * rhs;
        product = product >>> FracBits;
        // Accumulate with saturation at the signed 64-bit limits.
        wide = {row_sum[AccW-1], row_sum} + {product[AccW-1], product};
        if (wide[AccW] != wide[AccW-1]) begin
          row_sum = wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        end else begin
          row_sum = wide[AccW-1:0];
        end
        if (item.row_end) begin
          close_row(row_sum);
        end
      end
      OP_EMPTY: begin
        close_row('0);
      end
      default: begin
        // The reserved opcode leaves everything as it was.
      end
    endcase
  endtask

  // Compares one accepted row result with the oldest expectation.
  task automatic check_row(input out_item_t got);
    out_item_t want;
    if (expected_rows.size() == 0) begin
      $error("row result with none expected: row_number %0d row_value %0d saturated %0b",
             got.row_number, got.row_value, got.saturated);
      fail_count++;
    end else begin
      want = expected_rows.pop_front();
      if (got.row_number !== want.row_number) begin
        $error("row_number: expected %0d, got %0d", want.row_number, got.row_number);
        fail_count++;
      end
      if (got.row_value !== want.row_value) begin
        $error("row_value: expected %0d, got %0d", want.row_value, got.row_value);
        fail_count++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        fail_count++;
      end
    end
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum = '0;
      row_idx = '0;
      expected_rows.delete();
      fail_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_row(out_item_i);
      end
      if (in_valid_i && in_ready_i) begin
        predict_row(in_item_i);
      end
      fail_count_o <= fail_count;
      pending_o <= expected_rows.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

// Drives the sparse matrix-vector multiply with directed and random matrix
// streams under varying back-pressure; the row checker beside the block
// predicts and compares every row result.
module tb;
  import smv_pkg::*;

  localparam opcode_t     OP_RESERVED = 2'd3;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned TailCycles  = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;

  // Vector positions loaded so far, so that rows only read loaded elements.
  bit          col_loaded [DefVecDepth];
  int unsigned loaded_cols [$];

  always #5 clk = ~clk;

  sparse_matrix_vector_multiply dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  smv_row_check i_row_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // A run that hangs ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_item_t mk_item(opcode_t op, logic [IndexW-1:0] idx,
                                       logic [DataW-1:0] val, logic re);
    in_item_t item;
    item.opcode  = op;
    item.index   = idx;
    item.value   = val;
    item.row_end = re;
    return item;
  endfunction

  // Full-range values, small Q16.16 numbers near zero and the extremes.
  function automatic logic [DataW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom;
    if (sel < 8) return $urandom_range(0, 1048575) - 32'd524288;
    if (sel == 8) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  function automatic logic [IndexW-1:0] pick_col();
    return IndexW'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    if (item.opcode == OP_LOAD && !col_loaded[item.index]) begin
      col_loaded[item.index] = 1'b1;
      loaded_cols.push_back(item.index);
    end
  endtask

  task automatic send_row(input int unsigned len, input logic closed);
    for (int unsigned k = 1; k <= len; k++) begin
      send_item(mk_item(OP_NONZERO, pick_col(), pick_value(), closed && k == len));
    end
  endtask

  // Mostly well-formed rows with random content, plus vector reloads,
  // rows broken off by a load or an empty row, and reserved opcodes.
  task automatic random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned sel;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          send_item(mk_item(OP_LOAD, IndexW'($urandom_range(0, DefVecDepth - 1)),
                            pick_value(), 1'($urandom_range(1))));
        end
        sent += len;
      end else if (sel < 11) begin
        send_item(mk_item(OP_RESERVED, IndexW'($urandom), $urandom,
                          1'($urandom_range(1))));
      end else if (sel < 22) begin
        send_item(mk_item(OP_EMPTY, IndexW'($urandom), $urandom, 1'($urandom_range(1))));
        sent++;
      end else if (sel < 27) begin
        len = $urandom_range(1, 4);
        send_row(len, 1'b0);
        if ($urandom_range(1)) begin
          send_item(mk_item(OP_EMPTY, IndexW'($urandom), $urandom,
                            1'($urandom_range(1))));
        end else begin
          send_item(mk_item(OP_LOAD, IndexW'($urandom_range(0, DefVecDepth - 1)),
                            pick_value(), 1'b0));
        end
        sent += len + 1;
      end else begin
        len = $urandom_range(1, 6);
        send_row(len, 1'b1);
        sent += len;
      end
    end
  endtask

  initial begin
    in_idle_pct = 17;
    out_idle_pct = 70;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Vector with the extremes at both ends of the store; row_end on a load
    // is ignored.
    send_item(mk_item(OP_LOAD, 10'd0, 32'h7FFF_FFFF, 1'b0));
    send_item(mk_item(OP_LOAD, 10'd1023, 32'h8000_0000, 1'b1));
    send_item(mk_item(OP_LOAD, 10'd1, 32'h0001_0000, 1'b0));
    send_item(mk_item(OP_LOAD, 10'd2, 32'hFFFF_FFFF, 1'b0));
    send_item(mk_item(OP_LOAD, 10'd512, 32'h0001_8000, 1'b0));
    // Single-nonzero rows: plain, rounding toward minus infinity, and
    // clipping in both directions.
    send_item(mk_item(OP_NONZERO, 10'd1, 32'h0002_0000, 1'b1));
    send_item(mk_item(OP_NONZERO, 10'd2, 32'h0000_0001, 1'b1));
    send_item(mk_item(OP_NONZERO, 10'd0, 32'h7FFF_FFFF, 1'b1));
    send_item(mk_item(OP_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b1));
    send_item(mk_item(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b1));
    send_item(mk_item(OP_NONZERO, 10'd0, 32'h8000_0000, 1'b1));
    // An empty row discards a partial sum; row_end is ignored on it.
    send_item(mk_item(OP_NONZERO, 10'd1, 32'h0003_0000, 1'b0));
    send_item(mk_item(OP_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b1));
    send_item(mk_item(OP_EMPTY, 10'd0, 32'h0000_0000, 1'b0));
    // The reserved opcode changes nothing.
    send_item(mk_item(OP_RESERVED, 10'd1023, 32'hFFFF_FFFF, 1'b1));
    // A row of three nonzeros.
    send_item(mk_item(OP_NONZERO, 10'd512, 32'h0001_0000, 1'b0));
    send_item(mk_item(OP_NONZERO, 10'd1, 32'hFFFF_0000, 1'b0));
    send_item(mk_item(OP_NONZERO, 10'd2, 32'h0000_0003, 1'b1));
    // A load in the middle of a row restarts the sum and the row numbering.
    send_item(mk_item(OP_NONZERO, 10'd1, 32'h1234_5678, 1'b0));
    send_item(mk_item(OP_LOAD, 10'd3, 32'h0000_0000, 1'b0));
    send_item(mk_item(OP_NONZERO, 10'd3, 32'h7FFF_FFFF, 1'b1));

    random_traffic(300);
    in_idle_pct = 70;
    out_idle_pct = 17;
    random_traffic(300);
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_traffic(300);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/smv_pkg.sv
rtl/core/smv_ram.sv
rtl/core/smv_front.sv
rtl/core/smv_queue.sv
rtl/core/smv_back.sv
rtl/core/sparse_matrix_vector_multiply.sv
test/smv_row_check.sv
test/tb.sv
